### src/mfd_pkg.sv
// Shared types, constants and helpers of the modulated feedback delay.
// Used by mfd_mul, mfd_core and the modulated_feedback_delay top level.
// Has no dependencies of its own.
package mfd_pkg;

  // Default sizing of the delay line and the hash seed.
  localparam int unsigned LineDepthDef = 262144;
  localparam logic [31:0] VariationSeedDef = 32'd0;

  // Width of the configuration write data (widest register).
  localparam int unsigned CfgDataW = 27;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;

  // Hash mixing constants.
  localparam logic [31:0] MixC1 = 32'd2246822507;
  localparam logic [31:0] MixC2 = 32'd3266489909;

  // Stored sample limit (+-8.0 in Q.19) and output saturation bounds.
  localparam logic signed [25:0] StoreLimit = 26'sd4194304;
  localparam logic signed [48:0] OutMax     = 49'sd33554431;
  localparam logic signed [48:0] OutMin     = -49'sd33554432;

  // Register reset values.
  localparam logic [25:0] DelayLengthRst  = 26'd4300800;
  localparam logic [15:0] FeedbackGainRst = 16'd26214;
  localparam logic [16:0] MixGainRst      = 17'd22938;
  localparam logic [17:0] OutputLevelRst  = 18'd65536;

  // Register range limits.
  localparam logic [15:0] FeedbackMax = 16'd62259;
  localparam logic [16:0] MixMax      = 17'd65536;
  localparam logic [17:0] LevelMax    = 18'd131072;
  localparam logic [15:0] DepthMax    = 16'd32768;
  localparam logic [26:0] StepMax     = 27'd67108864;
  localparam logic [16:0] SpreadMax   = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DELAY_LENGTH  = 3'd0,
    CFG_FEEDBACK_GAIN = 3'd1,
    CFG_MIX_GAIN      = 3'd2,
    CFG_OUTPUT_LEVEL  = 3'd3,
    CFG_MOD_DEPTH     = 3'd4,
    CFG_MOD_STEP      = 3'd5,
    CFG_MOD_SPREAD    = 3'd6,
    CFG_INVERT_MODE   = 3'd7
  } cfg_idx_e;

  // Configuration as seen by the datapath; all but the delay length are
  // already limited to their ranges.
  typedef struct packed {
    logic [25:0] delay_length;
    logic [15:0] feedback_gain;
    logic [16:0] mix_gain;
    logic [17:0] output_level;
    logic [15:0] mod_depth;
    logic [26:0] mod_step;
    logic [16:0] mod_spread;
    logic        invert_mode;
  } cfg_t;

  // Saturate a wide signed value to the 26 bit output range.
  function automatic logic signed [25:0] sat_out(input logic signed [48:0] v);
    logic signed [48:0] r;
    begin
      if (v > OutMax) begin
        r = OutMax;
      end else if (v < OutMin) begin
        r = OutMin;
      end else begin
        r = v;
      end
      return r[25:0];
    end
  endfunction

endpackage

### src/mfd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mfd_pkg for the operand and product widths.
// The product of the operands presented in one cycle is valid in the next.
module mfd_mul (
  input  logic                              clk_i,
  input  logic signed [mfd_pkg::MulW-1:0]   a_i,
  input  logic signed [mfd_pkg::MulW-1:0]   b_i,
  output logic signed [mfd_pkg::ProdW-1:0]  p_o
);

  logic signed [mfd_pkg::ProdW-1:0] p_q;

  // One full-width signed product per cycle.
  always_ff @(posedge clk_i) begin
    p_q <= mfd_pkg::ProdW'(a_i) * mfd_pkg::ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

### src/mfd_core.sv
// Sequencer, delay memory and datapath of the modulated feedback delay.
// Depends on mfd_pkg and instantiates mfd_mul; the delay line is a
// synchronous memory with one read and one write port.
module mfd_core #(
  parameter int unsigned LINE_DEPTH     = mfd_pkg::LineDepthDef,
  parameter logic [31:0] VARIATION_SEED = mfd_pkg::VariationSeedDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfd_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [23:0]  dry_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [25:0]  mixed_out_o,
  output logic signed [25:0]  wet_out_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned RW = AW + 9;
  localparam logic [RW-1:0] Span = RW'(LINE_DEPTH) << 8;
  localparam logic [27:0] DlenMax = 28'((LINE_DEPTH - 2) * 256);
  localparam logic [AW-1:0] LastAddr = AW'(LINE_DEPTH - 1);

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_VIDX, S_H1, S_H2, S_TGT, S_DIFF, S_VAR, S_SPR, S_FAC,
    S_PHS, S_PHA, S_TRI, S_M, S_DM, S_OFF, S_RPOS, S_WRAP, S_RD0, S_RD1,
    S_INT, S_TAP, S_FBM, S_WR, S_WET1, S_WET2, S_MXA, S_MXB, S_MXC,
    S_LVH, S_LVL, S_WOM, S_DONE
  } state_e;

  state_e state_q;

  // Persistent state.
  logic [31:0]        phase_q;
  logic [AW-1:0]      wp_q;
  logic signed [17:0] var_q;

  // Per-item working registers.
  logic signed [23:0] dry_q;
  logic signed [18:0] diff_q;
  logic [17:0]        fac_q;
  logic [16:0]        g_q;
  logic               tri_top_q;
  logic [16:0]        m_q;
  logic [26:0]        off_q;
  logic [RW-1:0]      rp_q;
  logic [AW-1:0]      before_q;
  logic [AW-1:0]      after_q;
  logic [7:0]         frac_q;
  logic signed [23:0] s0_q;
  logic signed [23:0] tap_q;
  logic signed [40:0] dfb_q;
  logic signed [25:0] wet_q;
  logic signed [44:0] acc_q;
  logic signed [47:0] hi_q;
  logic signed [25:0] mixed_res_q;

  // Output register.
  logic               out_valid_q;
  logic signed [25:0] mixed_out_q;
  logic signed [25:0] wet_out_q;

  // Memory and multiplier ports.
  logic [23:0]      mem_q [LINE_DEPTH];
  logic signed [23:0] rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_raddr;
  logic             mem_re;
  logic signed [23:0] mem_wdata;
  logic signed [mfd_pkg::MulW-1:0]  mul_a;
  logic signed [mfd_pkg::MulW-1:0]  mul_b;
  logic signed [mfd_pkg::ProdW-1:0] p;

  // Combinational helpers.
  logic [25:0]        dlen;
  logic [31:0]        vidx;
  logic [31:0]        x1a;
  logic [31:0]        x1;
  logic [31:0]        x2;
  logic [31:0]        hsh;
  logic signed [19:0] tgt;
  logic signed [19:0] vsum;
  logic signed [19:0] fsum;
  logic [33:0]        tri_w;
  logic [RW-1:0]      rp_wrap;
  logic signed [24:0] sdiff;
  logic signed [33:0] tsum;
  logic signed [25:0] fbp;
  logic signed [25:0] wr;
  logic signed [23:0] wr_clamped;
  logic signed [41:0] wdiff;
  logic signed [48:0] msum;
  logic               accept;
  logic               can_load;

  assign accept   = in_valid_i && !in_stall_o;
  assign can_load = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Base delay limited to one sample and to the line depth minus two.
  always_comb begin
    if (cfg_i.delay_length < 26'd256) begin
      dlen = 26'd256;
    end else if (28'(cfg_i.delay_length) > DlenMax) begin
      dlen = 26'(DlenMax);
    end else begin
      dlen = cfg_i.delay_length;
    end
  end

  // Hash stages, target, smoothing, LFO, read position, interpolation, feedback and mix arithmetic.
  always_comb begin
    vidx  = p[63:32] + 32'(wp_q);
    x1a   = vidx ^ VARIATION_SEED;
    x1    = x1a ^ (x1a >> 16);
    x2    = p[31:0] ^ (p[31:0] >> 13);
    hsh   = p[31:0] ^ (p[31:0] >> 16);
    tgt   = $signed({3'b000, hsh[31:15]}) - 20'sd65536;
    vsum  = 20'(var_q) + 20'(p >>> 32);
    fsum  = 20'(p >>> 16) + 20'sd65536;
    tri_w = phase_q[31] ? (34'h2_0000_0000 - {1'b0, phase_q, 1'b0})
                        : {1'b0, phase_q, 1'b0};
    rp_wrap = (rp_q >= Span) ? (rp_q - Span) : rp_q;
    sdiff = 25'(rdata_q) - 25'(s0_q);
    tsum  = {{2{s0_q[23]}}, s0_q, 8'b0} + 34'(p);
    fbp   = 26'(p >>> 16);
    wr    = cfg_i.invert_mode ? (-26'(dry_q) - fbp) : (26'(dry_q) + fbp);
    wdiff = 42'(dfb_q) - 42'(p);
    msum  = 49'(hi_q) + 49'(p >>> 16);
  end

  // Stored sample limit.
  always_comb begin
    if (wr > mfd_pkg::StoreLimit) begin
      wr_clamped = 24'(mfd_pkg::StoreLimit);
    end else if (wr < -mfd_pkg::StoreLimit) begin
      wr_clamped = 24'(-mfd_pkg::StoreLimit);
    end else begin
      wr_clamped = 24'(wr);
    end
  end

  // Multiplier operand selection per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_VIDX: begin
        mul_a = 33'(phase_q);
        mul_b = 33'(10'd997);
      end
      S_H1: begin
        mul_a = 33'(x1);
        mul_b = 33'(mfd_pkg::MixC1);
      end
      S_H2: begin
        mul_a = 33'(x2);
        mul_b = 33'(mfd_pkg::MixC2);
      end
      S_DIFF: begin
        mul_a = 33'(diff_q);
        mul_b = 33'(cfg_i.mod_step);
      end
      S_SPR: begin
        mul_a = 33'(var_q);
        mul_b = 33'(cfg_i.mod_spread);
      end
      S_PHS: begin
        mul_a = 33'(cfg_i.mod_step);
        mul_b = 33'(fac_q);
      end
      S_PHA: begin
        mul_a = 33'(cfg_i.feedback_gain);
        mul_b = 33'(cfg_i.feedback_gain);
      end
      S_TRI: begin
        mul_a = 33'(tri_w[31:0]);
        mul_b = 33'(cfg_i.mod_depth);
      end
      S_DM: begin
        mul_a = 33'(dlen);
        mul_b = 33'(m_q);
      end
      S_INT: begin
        mul_a = 33'(sdiff);
        mul_b = 33'(frac_q);
      end
      S_FBM: begin
        mul_a = 33'(tap_q);
        mul_b = 33'(cfg_i.feedback_gain);
      end
      S_WR: begin
        mul_a = 33'(dry_q);
        mul_b = 33'(cfg_i.feedback_gain);
      end
      S_WET1: begin
        mul_a = 33'(tap_q);
        mul_b = 33'(g_q);
      end
      S_MXA: begin
        mul_a = 33'(dry_q);
        mul_b = 33'(17'd65536 - cfg_i.mix_gain);
      end
      S_MXB: begin
        mul_a = 33'(wet_q);
        mul_b = 33'(cfg_i.mix_gain);
      end
      S_LVH: begin
        mul_a = 33'(acc_q >>> 16);
        mul_b = 33'(cfg_i.output_level);
      end
      S_LVL: begin
        mul_a = 33'(acc_q[15:0]);
        mul_b = 33'(cfg_i.output_level);
      end
      S_WOM, S_DONE: begin
        mul_a = 33'(wet_q);
        mul_b = 33'(cfg_i.output_level);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mfd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  // Memory port control: clearing sweep, tap reads and the line write.
  assign mem_we    = (state_q == S_CLR) || (state_q == S_WR);
  assign mem_wdata = (state_q == S_CLR) ? 24'sd0 : wr_clamped;
  assign mem_re    = (state_q == S_RD0) || (state_q == S_RD1);
  assign mem_raddr = (state_q == S_RD1) ? after_q : before_q;

  // Delay line memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer with state and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      phase_q     <= '0;
      wp_q        <= '0;
      var_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The final step reloads the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          if (wp_q == LastAddr) begin
            wp_q    <= '0;
            state_q <= S_IDLE;
          end else begin
            wp_q <= wp_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            dry_q   <= dry_sample_i;
            state_q <= S_VIDX;
          end
        end
        S_VIDX: state_q <= S_H1;
        S_H1:   state_q <= S_H2;
        S_H2:   state_q <= S_TGT;
        S_TGT: begin
          diff_q  <= 19'(tgt - 20'(var_q));
          state_q <= S_DIFF;
        end
        S_DIFF: state_q <= S_VAR;
        S_VAR: begin
          if (vsum > 20'sd65536) begin
            var_q <= 18'sd65536;
          end else if (vsum < -20'sd65536) begin
            var_q <= -18'sd65536;
          end else begin
            var_q <= 18'(vsum);
          end
          state_q <= S_SPR;
        end
        S_SPR: state_q <= S_FAC;
        S_FAC: begin
          fac_q   <= fsum[19] ? 18'd0 : 18'(fsum);
          state_q <= S_PHS;
        end
        S_PHS: state_q <= S_PHA;
        S_PHA: begin
          phase_q <= phase_q + p[47:16];
          state_q <= S_TRI;
        end
        S_TRI: begin
          g_q       <= 17'd65536 - 17'(p[31:16]);
          tri_top_q <= tri_w[32];
          state_q   <= S_M;
        end
        S_M: begin
          m_q     <= tri_top_q ? 17'(cfg_i.mod_depth) : 17'(p[47:32]);
          state_q <= S_DM;
        end
        S_DM: begin
          wp_q    <= (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
          state_q <= S_OFF;
        end
        S_OFF: begin
          off_q   <= 27'(dlen) - 27'(p[42:16]) + 27'd256;
          state_q <= S_RPOS;
        end
        S_RPOS: begin
          rp_q    <= {wp_q, 8'b0} + Span - RW'(off_q);
          state_q <= S_WRAP;
        end
        S_WRAP: begin
          before_q <= rp_wrap[AW+7:8];
          frac_q   <= rp_wrap[7:0];
          state_q  <= S_RD0;
        end
        S_RD0: begin
          after_q <= (before_q == LastAddr) ? '0 : before_q + 1'b1;
          state_q <= S_RD1;
        end
        S_RD1: begin
          s0_q    <= rdata_q;
          state_q <= S_INT;
        end
        S_INT: state_q <= S_TAP;
        S_TAP: begin
          tap_q   <= 24'(tsum >>> 8);
          state_q <= S_FBM;
        end
        S_FBM: state_q <= S_WR;
        S_WR:  state_q <= S_WET1;
        S_WET1: begin
          dfb_q   <= 41'(p);
          state_q <= S_WET2;
        end
        S_WET2: begin
          wet_q   <= cfg_i.invert_mode ? 26'(wdiff >>> 16) : 26'(tap_q);
          state_q <= S_MXA;
        end
        S_MXA: state_q <= S_MXB;
        S_MXB: begin
          acc_q   <= 45'(p);
          state_q <= S_MXC;
        end
        S_MXC: begin
          acc_q   <= acc_q + 45'(p);
          state_q <= S_LVH;
        end
        S_LVH: state_q <= S_LVL;
        S_LVL: begin
          hi_q    <= 48'(p);
          state_q <= S_WOM;
        end
        S_WOM: begin
          mixed_res_q <= mfd_pkg::sat_out(msum >>> 16);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            mixed_out_q <= mixed_res_q;
            wet_out_q   <= mfd_pkg::sat_out(49'(p >>> 16));
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign mixed_out_o = mixed_out_q;
  assign wet_out_o   = wet_out_q;

  // A new result only appears when the sequence finishes.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the final step");

  // The write pointer never leaves the line.
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW+1)'(wp_q) < (AW+1)'(LINE_DEPTH))
    else $error("write pointer beyond line depth");

  // The smoothed variation stays within plus or minus one.
  a_var_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (var_q <= 18'sd65536) && (var_q >= -18'sd65536))
    else $error("rate variation out of range");

  // An accepted transaction starts the hash sequence.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_VIDX))
    else $error("accepted item did not start the sequence");

  // The line is written only by the clearing sweep or the feedback write.
  a_write_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_CLR) || (state_q == S_WR)))
    else $error("unexpected delay line write");

endmodule

### src/modulated_feedback_delay.sv
// Modulated feedback delay: the result of an accepted input transaction is
// offered when its pass through a shared multiplier and the delay memory
// ends; items go one at a time, the next taken once the result is loaded.
// After reset the line memory is cleared, one entry per cycle, over all
// LINE_DEPTH entries (262144 by default) before the first item is taken.
// Configuration registers reset to their defaults; depends on mfd_pkg, mfd_core.
module modulated_feedback_delay #(
  parameter int unsigned LINE_DEPTH     = mfd_pkg::LineDepthDef,
  parameter logic [31:0] VARIATION_SEED = mfd_pkg::VariationSeedDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [mfd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [23:0]            dry_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [25:0]            mixed_out_o,
  output logic signed [25:0]            wet_out_o
);

  logic [25:0] delay_length_q;
  logic [15:0] feedback_gain_q;
  logic [16:0] mix_gain_q;
  logic [17:0] output_level_q;
  logic [15:0] mod_depth_q;
  logic [26:0] mod_step_q;
  logic [16:0] mod_spread_q;
  logic        invert_mode_q;
  mfd_pkg::cfg_t cfg;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q  <= mfd_pkg::DelayLengthRst;
      feedback_gain_q <= mfd_pkg::FeedbackGainRst;
      mix_gain_q      <= mfd_pkg::MixGainRst;
      output_level_q  <= mfd_pkg::OutputLevelRst;
      mod_depth_q     <= '0;
      mod_step_q      <= '0;
      mod_spread_q    <= '0;
      invert_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mfd_pkg::cfg_idx_e'(cfg_index_i))
        mfd_pkg::CFG_DELAY_LENGTH:  delay_length_q  <= cfg_data_i[25:0];
        mfd_pkg::CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[15:0];
        mfd_pkg::CFG_MIX_GAIN:      mix_gain_q      <= cfg_data_i[16:0];
        mfd_pkg::CFG_OUTPUT_LEVEL:  output_level_q  <= cfg_data_i[17:0];
        mfd_pkg::CFG_MOD_DEPTH:     mod_depth_q     <= cfg_data_i[15:0];
        mfd_pkg::CFG_MOD_STEP:      mod_step_q      <= cfg_data_i[26:0];
        mfd_pkg::CFG_MOD_SPREAD:    mod_spread_q    <= cfg_data_i[16:0];
        mfd_pkg::CFG_INVERT_MODE:   invert_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Limit each register to its range before use.
  always_comb begin
    cfg.delay_length  = delay_length_q;
    cfg.feedback_gain = (feedback_gain_q > mfd_pkg::FeedbackMax) ?
                        mfd_pkg::FeedbackMax : feedback_gain_q;
    cfg.mix_gain      = (mix_gain_q > mfd_pkg::MixMax) ? mfd_pkg::MixMax : mix_gain_q;
    cfg.output_level  = (output_level_q > mfd_pkg::LevelMax) ?
                        mfd_pkg::LevelMax : output_level_q;
    cfg.mod_depth     = (mod_depth_q > mfd_pkg::DepthMax) ? mfd_pkg::DepthMax : mod_depth_q;
    cfg.mod_step      = (mod_step_q > mfd_pkg::StepMax) ? mfd_pkg::StepMax : mod_step_q;
    cfg.mod_spread    = (mod_spread_q > mfd_pkg::SpreadMax) ?
                        mfd_pkg::SpreadMax : mod_spread_q;
    cfg.invert_mode   = invert_mode_q;
  end

  mfd_core #(
    .LINE_DEPTH     (LINE_DEPTH),
    .VARIATION_SEED (VARIATION_SEED)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .dry_sample_i (dry_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mixed_out_o  (mixed_out_o),
    .wet_out_o    (wet_out_o)
  );

endmodule
